// ===== hdl/isp_pkg.sv =====
`default_nettype none

package isp_pkg;

    localparam int DEPTH       = 4096;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int OUTPUT_RATE = 48000;

    localparam int FUNC_W    = 2;
    localparam int SADDR_W   = 12;
    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 13;
    localparam int RATE_W    = 18;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;

    localparam int POS_W  = 32;
    localparam int STEP_W = 24;
    localparam int FRAC_W = 16;
    localparam int IDX_W  = POS_W - FRAC_W;
    localparam int CMP_W  = IDX_W + 1;
    localparam int MIX_W  = SAMPLE_W + FRAC_W + 2;

    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    function automatic int trailing_zeros(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x != 0 && x[0] == 1'b0) begin
            x = x >>> 1;
            n = n + 1;
        end
        return n;
    endfunction

    // step = floor(rate * 2^16 / OUTPUT_RATE) as rate * RECIP_M >> RECIP_SHIFT (exact)
    localparam int RATE_TZ     = trailing_zeros(OUTPUT_RATE);
    localparam int RATE_ODD    = OUTPUT_RATE >> RATE_TZ;
    localparam int RATE_EXP    = FRAC_W - RATE_TZ;
    localparam int RECIP_S     = RATE_W + RATE_EXP + $clog2(RATE_ODD);
    localparam longint unsigned RECIP_M =
        ((64'd1 << RECIP_S) + longint'(RATE_ODD) - 1) / longint'(RATE_ODD);
    localparam int RECIP_W     = $clog2(RECIP_M + 1);
    localparam int RECIP_SHIFT = RECIP_S - RATE_EXP;
    localparam int PROD_W      = RATE_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE = 2'd0,
        FN_START = 2'd1,
        FN_STOP  = 2'd2,
        FN_TICK  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        BS_RUN,
        BS_SECOND,
        BS_HOLD
    } t_bstate;

    typedef struct packed {
        t_func                       func;
        logic [ADDR_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0]  value;
        logic [STEP_W-1:0]           step;
    } t_item;

endpackage

`default_nettype wire

// ===== hdl/isp_front.sv =====
`default_nettype none

module isp_front (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  [isp_pkg::FUNC_W-1:0]           i_func,
    input  wire  [isp_pkg::SADDR_W-1:0]          i_sample_addr,
    input  wire  signed [isp_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  wire  [isp_pkg::RATE_W-1:0]           i_source_rate,
    output logic                                 o_push_valid,
    input  wire                                  i_push_ready,
    output isp_pkg::t_item                       o_push_item
);

    logic                                r_valid;
    isp_pkg::t_func                      r_func;
    logic [isp_pkg::ADDR_W-1:0]          r_addr;
    logic signed [isp_pkg::SAMPLE_W-1:0] r_value;
    logic                                r_rate_zero;
    logic [isp_pkg::PROD_W-1:0]          r_prod;

    logic                                accept;
    logic [isp_pkg::PROD_W-1:0]          quot;
    logic [isp_pkg::STEP_W-1:0]          step;

    assign o_in_ready = !r_valid || i_push_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func      <= isp_pkg::t_func'(i_func);
            r_addr      <= isp_pkg::ADDR_W'(i_sample_addr % isp_pkg::DEPTH);
            r_value     <= i_sample_value;
            r_rate_zero <= (i_source_rate == '0);
            r_prod      <= isp_pkg::PROD_W'(i_source_rate)
                           * isp_pkg::PROD_W'(isp_pkg::RECIP_M);
        end
    end

    assign quot = r_prod >> isp_pkg::RECIP_SHIFT;

    always_comb begin
        priority if (r_rate_zero) begin
            step = '0;
        end else if (quot == '0) begin
            step = isp_pkg::STEP_W'(1);
        end else if (quot > isp_pkg::PROD_W'(isp_pkg::STEP_MAX)) begin
            step = isp_pkg::STEP_MAX;
        end else begin
            step = quot[isp_pkg::STEP_W-1:0];
        end
    end

    assign o_push_valid      = r_valid;
    assign o_push_item.func  = r_func;
    assign o_push_item.addr  = r_addr;
    assign o_push_item.value = r_value;
    assign o_push_item.step  = step;

endmodule

`default_nettype wire

// ===== hdl/isp_queue.sv =====
`default_nettype none

module isp_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push_valid,
    output logic                o_push_ready,
    input  isp_pkg::t_item      i_push_item,
    output logic                o_pop_valid,
    input  wire                 i_pop,
    output isp_pkg::t_item      o_pop_item
);

    isp_pkg::t_item              r_slot [isp_pkg::QDEPTH];
    logic [isp_pkg::QPTR_W-1:0]  r_wptr;
    logic [isp_pkg::QPTR_W-1:0]  r_rptr;
    logic [isp_pkg::QCNT_W-1:0]  r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != isp_pkg::QCNT_W'(isp_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_item   = r_slot[r_rptr];

    function automatic logic [isp_pkg::QPTR_W-1:0] ptr_inc(
        input logic [isp_pkg::QPTR_W-1:0] p
    );
        return (p == isp_pkg::QPTR_W'(isp_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/isp_back.sv =====
`default_nettype none

module isp_back (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_pop_valid,
    output logic                                 o_pop,
    input  isp_pkg::t_item                       i_pop_item,
    input  wire  [isp_pkg::LEN_W-1:0]            i_sound_length,
    input  wire                                  i_loop_enable,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic signed [isp_pkg::SAMPLE_W-1:0]  o_audio_sample,
    output logic                                 o_playing
);

    typedef struct packed {
        logic                                mix;
        logic                                playing;
        logic signed [isp_pkg::SAMPLE_W-1:0] s0;
        logic [isp_pkg::FRAC_W-1:0]          frac;
    } t_bslot;

    // sample store
    logic signed [isp_pkg::SAMPLE_W-1:0] r_mem [isp_pkg::DEPTH];
    logic signed [isp_pkg::SAMPLE_W-1:0] r_rd_data;

    // playback state
    logic [isp_pkg::POS_W-1:0]   r_pos;
    logic [isp_pkg::STEP_W-1:0]  r_step;
    logic                        r_active;
    isp_pkg::t_bstate            r_state;
    logic [isp_pkg::ADDR_W-1:0]  r_addr2;
    logic [isp_pkg::FRAC_W-1:0]  r_frac;
    logic signed [isp_pkg::SAMPLE_W-1:0] r_s0;

    // mix stage and result register
    logic                        r_b_valid;
    t_bslot                      r_b;
    logic                        r_out_valid;
    logic signed [isp_pkg::SAMPLE_W-1:0] r_audio;
    logic                        r_playing;

    logic [isp_pkg::POS_W-1:0]   n_pos;
    logic [isp_pkg::STEP_W-1:0]  n_step;
    logic                        n_active;
    isp_pkg::t_bstate            n_state;

    logic                        b_adv;
    logic                        b_free;
    logic                        b_load;
    t_bslot                      b_next;
    logic                        mem_we;
    logic                        mem_re;
    logic [isp_pkg::ADDR_W-1:0]  mem_addr;
    logic                        tick_go;

    logic [isp_pkg::CMP_W-1:0]   len;
    logic [isp_pkg::IDX_W-1:0]   idx;
    logic                        over;
    logic                        wrap;
    logic                        silent;
    logic [isp_pkg::IDX_W-1:0]   eff_idx;
    logic [isp_pkg::FRAC_W-1:0]  eff_frac;
    logic [isp_pkg::POS_W-1:0]   eff_pos;
    logic [isp_pkg::CMP_W-1:0]   nxt;
    logic [isp_pkg::ADDR_W-1:0]  addr2;

    logic signed [isp_pkg::SAMPLE_W:0]        diff;
    logic signed [2*isp_pkg::SAMPLE_W+1:0]    wprod;
    logic signed [isp_pkg::MIX_W-1:0]         mix;
    logic signed [isp_pkg::SAMPLE_W-1:0]      mix_audio;

    assign b_adv  = r_b_valid && (!r_out_valid || i_out_ready);
    assign b_free = !r_b_valid || b_adv;

    // tick decode
    assign len = (i_sound_length > isp_pkg::DEPTH) ? isp_pkg::CMP_W'(isp_pkg::DEPTH)
                                                   : isp_pkg::CMP_W'(i_sound_length);
    assign idx      = r_pos[isp_pkg::POS_W-1:isp_pkg::FRAC_W];
    assign over     = ({1'b0, idx} >= len);
    assign wrap     = over && i_loop_enable;
    assign silent   = !r_active || (len == '0) || (r_step == '0);
    assign eff_idx  = wrap ? '0 : idx;
    assign eff_frac = wrap ? '0 : r_pos[isp_pkg::FRAC_W-1:0];
    assign eff_pos  = wrap ? '0 : r_pos;
    assign nxt      = {1'b0, eff_idx} + 1'b1;
    assign addr2    = (nxt < len) ? isp_pkg::ADDR_W'(nxt) : isp_pkg::ADDR_W'(eff_idx);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isp_pkg::BS_RUN: begin
                if (tick_go) begin
                    n_state = isp_pkg::BS_SECOND;
                end
            end
            isp_pkg::BS_SECOND,
            isp_pkg::BS_HOLD: begin
                n_state = b_free ? isp_pkg::BS_RUN : isp_pkg::BS_HOLD;
            end
            default: n_state = isp_pkg::BS_RUN;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = i_pop_item.addr;
        b_load   = 1'b0;
        b_next   = '{mix: 1'b0, playing: r_active, s0: r_rd_data, frac: r_frac};
        tick_go  = 1'b0;
        n_pos    = r_pos;
        n_step   = r_step;
        n_active = r_active;
        unique case (r_state)
            isp_pkg::BS_RUN: begin
                if (i_pop_valid && b_free) begin
                    o_pop = 1'b1;
                    unique case (i_pop_item.func)
                        isp_pkg::FN_WRITE: begin
                            mem_we = 1'b1;
                            b_load = 1'b1;
                        end
                        isp_pkg::FN_START: begin
                            if (!r_active) begin
                                n_pos    = '0;
                                n_step   = i_pop_item.step;
                                n_active = 1'b1;
                            end
                            b_load         = 1'b1;
                            b_next.playing = 1'b1;
                        end
                        isp_pkg::FN_STOP: begin
                            n_pos          = '0;
                            n_step         = '0;
                            n_active       = 1'b0;
                            b_load         = 1'b1;
                            b_next.playing = 1'b0;
                        end
                        isp_pkg::FN_TICK: begin
                            if (silent) begin
                                b_load = 1'b1;
                            end else if (over && !wrap) begin
                                n_pos          = '0;
                                n_step         = '0;
                                n_active       = 1'b0;
                                b_load         = 1'b1;
                                b_next.playing = 1'b0;
                            end else begin
                                mem_re   = 1'b1;
                                mem_addr = isp_pkg::ADDR_W'(eff_idx);
                                n_pos    = eff_pos + isp_pkg::POS_W'(r_step);
                                tick_go  = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            isp_pkg::BS_SECOND: begin
                mem_re   = 1'b1;
                mem_addr = r_addr2;
                if (b_free) begin
                    b_load = 1'b1;
                    b_next = '{mix: 1'b1, playing: 1'b1, s0: r_rd_data, frac: r_frac};
                end
            end
            isp_pkg::BS_HOLD: begin
                if (b_free) begin
                    b_load = 1'b1;
                    b_next = '{mix: 1'b1, playing: 1'b1, s0: r_s0, frac: r_frac};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= isp_pkg::BS_RUN;
            r_pos    <= '0;
            r_step   <= '0;
            r_active <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_step   <= n_step;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_addr2 <= addr2;
            r_frac  <= eff_frac;
        end
        if (r_state == isp_pkg::BS_SECOND) begin
            r_s0 <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_pop_item.value;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    // s0 + (s1 - s0) * f, floor of >> 16; s1 is the registered read data
    assign diff  = $signed({r_rd_data[isp_pkg::SAMPLE_W-1], r_rd_data})
                 - $signed({r_b.s0[isp_pkg::SAMPLE_W-1], r_b.s0});
    assign wprod = diff * $signed({1'b0, r_b.frac});
    assign mix   = $signed({{(isp_pkg::MIX_W-isp_pkg::SAMPLE_W-isp_pkg::FRAC_W)
                              {r_b.s0[isp_pkg::SAMPLE_W-1]}},
                             r_b.s0, {isp_pkg::FRAC_W{1'b0}}})
                 + isp_pkg::MIX_W'(wprod);
    assign mix_audio = mix[isp_pkg::FRAC_W +: isp_pkg::SAMPLE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (b_load) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b <= b_next;
        end
        if (b_adv) begin
            r_audio   <= r_b.mix ? mix_audio : '0;
            r_playing <= r_b.playing;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_audio_sample = r_audio;
    assign o_playing      = r_playing;

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_pos == '0 && r_step == '0))
        else $error("position or step left set while idle");

    a_second_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == isp_pkg::BS_SECOND |=> r_state != isp_pkg::BS_SECOND)
        else $error("second read repeated");

    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("store read and written in one cycle");

    a_mix_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !b_adv |=> r_b_valid && $stable(r_b))
        else $error("mix stage lost its item");

    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> b_free && r_state == isp_pkg::BS_RUN)
        else $error("item taken without room behind it");

endmodule

`default_nettype wire

// ===== hdl/interpolating_sample_player_top.sv =====
// Path: front input register, queue slot, mix stage, result register; a tick
//   that reads the sample store also passes through the second-read state.
// Throughput: one item per cycle unless the output stalls; a tick that reads
//   the store uses the single store port twice (sample and its neighbor).
// Reset (synchronous, active low) clears control, playback state and config
//   registers; the sample store is not cleared and holds no valid bits.
`default_nettype none

module interpolating_sample_player_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  [isp_pkg::FUNC_W-1:0]           i_func,
    input  wire  [isp_pkg::SADDR_W-1:0]          i_sample_addr,
    input  wire  signed [isp_pkg::SAMPLE_W-1:0]  i_sample_value,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic signed [isp_pkg::SAMPLE_W-1:0]  o_audio_sample,
    output logic                                 o_playing,
    input  wire                                  i_cfg_we,
    input  wire  [isp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [isp_pkg::CFG_W-1:0]            i_cfg_data
);

    logic [isp_pkg::LEN_W-1:0]  r_sound_length;
    logic [isp_pkg::RATE_W-1:0] r_source_rate;
    logic                       r_loop_enable;

    logic                       push_valid;
    logic                       push_ready;
    isp_pkg::t_item             push_item;
    logic                       pop_valid;
    logic                       pop;
    isp_pkg::t_item             pop_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_length <= '0;
            r_source_rate  <= '0;
            r_loop_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                isp_pkg::CFG_SOUND_LENGTH: r_sound_length <= i_cfg_data[isp_pkg::LEN_W-1:0];
                isp_pkg::CFG_SOURCE_RATE:  r_source_rate  <= i_cfg_data[isp_pkg::RATE_W-1:0];
                isp_pkg::CFG_LOOP_ENABLE:  r_loop_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    isp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_sample_addr  (i_sample_addr),
        .i_sample_value (i_sample_value),
        .i_source_rate  (r_source_rate),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_item    (push_item)
    );

    isp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_item   (pop_item)
    );

    isp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (pop_valid),
        .o_pop          (pop),
        .i_pop_item     (pop_item),
        .i_sound_length (r_sound_length),
        .i_loop_enable  (r_loop_enable),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_audio_sample (o_audio_sample),
        .o_playing      (o_playing)
    );

endmodule

`default_nettype wire
